// ===== rtl/bti_pkg.sv =====
`default_nettype none

package bti_pkg;

    // Defaults for the top level parameters
    localparam int MAX_ENTRIES_DEF   = 64;
    localparam int FRACTION_BITS_DEF = 16;

    // Fixed field widths
    localparam int VAL_W = 32;
    localparam int RES_W = 48;
    localparam int CFG_W = 7;
    localparam int IDX_W = 6;

    typedef enum logic [1:0] {
        MODE_LOAD,
        MODE_INTERP,
        MODE_INTEG_TO,
        MODE_INTEG_ALL
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK,
        ST_SHORT,
        ST_ZERO_WIDTH,
        ST_SAT
    } t_status;

    // Datapath operations, one per cycle
    typedef enum logic [4:0] {
        OP_NOP,
        OP_START,
        OP_LD_FIRST,
        OP_LD_LAST,
        OP_LD_NEXT,
        OP_ADVANCE,
        OP_MUL_TERM,
        OP_S_ADD,
        OP_MUL_YDX,
        OP_MUL_2YDX,
        OP_MUL_UDY,
        OP_ACC_ADD,
        OP_SAVE_INNER,
        OP_MAC_S_DX,
        OP_MAC_IN_U,
        OP_DIV_INT,
        OP_DIV_SEG,
        OP_DIV_ALL,
        OP_RES_SHORT,
        OP_RES_ZW,
        OP_RES_Y0,
        OP_RES_YL,
        OP_PUBLISH
    } t_op;

    // Table read address select
    typedef enum logic [1:0] {
        RD_FIRST,
        RD_LAST,
        RD_NEXT
    } t_rd_sel;

    typedef struct packed {
        t_op     op;
        t_rd_sel rd_sel;
        logic    mem_we;
    } t_cmd;

    typedef struct packed {
        logic short_tbl;
        logic lt_first;
        logic gt_last;
        logic more_idx;
        logic below_t;
        logic dx_zero;
        logic mac_busy;
        logic div_busy;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/bti_datapath.sv =====
`default_nettype none

module bti_datapath #(
    parameter int MAX_ENTRIES   = bti_pkg::MAX_ENTRIES_DEF,
    parameter int FRACTION_BITS = bti_pkg::FRACTION_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [bti_pkg::CFG_W-1:0]          i_cfg_wr_data,
    input  logic [bti_pkg::IDX_W-1:0]          i_entry_index,
    input  logic signed [bti_pkg::VAL_W-1:0]   i_entry_x,
    input  logic signed [bti_pkg::VAL_W-1:0]   i_entry_y,
    input  logic signed [bti_pkg::VAL_W-1:0]   i_query_x,
    input  bti_pkg::t_cmd                      i_cmd,
    output bti_pkg::t_dp_status                o_flags,
    output logic signed [bti_pkg::RES_W-1:0]   o_result_value,
    output logic [1:0]                         o_status
);
    import bti_pkg::*;

    localparam int AW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int SW  = 66 + AW;             // running trapezoid sum
    localparam int IW  = 67;                  // inner term of last segment
    localparam int PW  = 67;                  // 34 x 33 product
    localparam int NW  = SW + 35;             // full numerator
    localparam int MBW = 33;                  // serial multiplier operand
    localparam int MCW = $clog2(MBW + 1);
    localparam int DW  = FRACTION_BITS + 34;  // divisor
    localparam int DCW = $clog2(NW + 1);

    // Breakpoint memory, {x, y} per entry
    logic [2*VAL_W-1:0] mem [MAX_ENTRIES];
    logic [2*VAL_W-1:0] r_rd;
    logic [AW-1:0]      rd_addr;
    logic               idx_ok;

    logic [CFG_W-1:0]          r_cfg;
    logic [CW-1:0]             n_eff;
    logic [AW-1:0]             r_idx;
    logic signed [VAL_W-1:0]   rd_x, rd_y;
    logic signed [VAL_W-1:0]   r_xa, r_ya, r_xb, r_yb, r_xl, r_yl, r_q, r_t;
    logic signed [VAL_W-1:0]   t_min, t_new;
    logic signed [SW-1:0]      r_s;
    logic signed [PW-1:0]      r_prod;
    logic signed [NW-1:0]      r_acc;
    logic signed [IW-1:0]      r_inner;

    // Serial multiplier
    logic signed [NW-1:0]      r_ma;
    logic [MBW-1:0]            r_mb;
    logic [MCW-1:0]            r_mcnt;

    // Restoring divider
    logic [NW-1:0]             r_dn;
    logic [DW-1:0]             r_dr, r_dd;
    logic                      r_dneg, r_dact;
    logic [DCW-1:0]            r_dcnt;

    logic signed [RES_W-1:0]   r_val, r_out_value;
    logic [1:0]                r_st, r_out_status;

    // Segment arithmetic
    logic signed [32:0]        dx, dy, u, ysum, y2;
    logic [32:0]               adx;
    logic signed [33:0]        mul_a;
    logic signed [32:0]        mul_b;
    logic signed [PW-1:0]      prod_c;

    // Divider helpers
    logic signed [NW-1:0]      num_src;
    logic                      num_neg;
    logic [NW-1:0]             num_mag;
    logic [DW:0]               r2;
    logic                      ge;
    logic                      rnd;
    logic [NW-1:0]             qf, lim;
    logic                      sat;
    logic [RES_W-1:0]          mag48;

    // Whole-table area, divisor is a power of two
    logic [NW-1:0]             sh_q, lim_a;
    logic                      sat_a;
    logic [RES_W-1:0]          mag_a;

    assign n_eff  = (32'(r_cfg) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(r_cfg);
    assign idx_ok = 32'(i_entry_index) < 32'(MAX_ENTRIES);
    assign rd_x   = r_rd[2*VAL_W-1:VAL_W];
    assign rd_y   = r_rd[VAL_W-1:0];

    // Read address
    always_comb begin
        case (i_cmd.rd_sel)
            RD_FIRST: rd_addr = '0;
            RD_LAST:  rd_addr = AW'(n_eff - CW'(1));
            default:  rd_addr = r_idx + AW'(1);
        endcase
    end

    // Table memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we && idx_ok) begin
            mem[AW'(i_entry_index)] <= {i_entry_x, i_entry_y};
        end
        r_rd <= mem[rd_addr];
    end

    assign dx   = 33'(r_xb) - 33'(r_xa);
    assign dy   = 33'(r_yb) - 33'(r_ya);
    assign u    = 33'(r_t) - 33'(r_xa);
    assign ysum = 33'(r_ya) + 33'(r_yb);
    assign y2   = {r_ya, 1'b0};
    assign adx  = dx[32] ? 33'(-dx) : 33'(dx);

    // Clamp target abscissa into the table span
    assign t_min = (r_q < rd_x) ? r_q : rd_x;
    assign t_new = (t_min < r_xa) ? r_xa : t_min;

    // Operand select for the combinational multiplier
    always_comb begin
        case (i_cmd.op)
            OP_MUL_YDX: begin
                mul_a = 34'(r_ya);
                mul_b = dx;
            end
            OP_MUL_2YDX: begin
                mul_a = 34'(y2);
                mul_b = dx;
            end
            OP_MUL_UDY: begin
                mul_a = 34'(u);
                mul_b = dy;
            end
            default: begin
                mul_a = 34'(ysum);
                mul_b = dx;
            end
        endcase
    end
    assign prod_c = mul_a * mul_b;

    // Divider start operands
    assign num_src = (i_cmd.op == OP_DIV_ALL) ? NW'(r_s) : r_acc;
    assign num_neg = num_src[NW-1];
    assign num_mag = num_neg ? NW'(-num_src) : NW'(num_src);

    // Divider step and final rounding
    assign r2    = {r_dr, r_dn[NW-1]};
    assign ge    = r2 >= {1'b0, r_dd};
    assign rnd   = {r_dr, 1'b0} >= {1'b0, r_dd};
    assign qf    = r_dn + NW'(rnd);
    assign lim   = r_dneg ? (NW'(1) << (RES_W - 1)) : ((NW'(1) << (RES_W - 1)) - NW'(1));
    assign sat   = qf > lim;
    assign mag48 = sat ? lim[RES_W-1:0] : qf[RES_W-1:0];

    // Whole-table area: shift out the fraction and the half, round on the top dropped bit
    assign sh_q  = (num_mag >> (FRACTION_BITS + 1)) + NW'(num_mag[FRACTION_BITS]);
    assign lim_a = num_neg ? (NW'(1) << (RES_W - 1)) : ((NW'(1) << (RES_W - 1)) - NW'(1));
    assign sat_a = sh_q > lim_a;
    assign mag_a = sat_a ? lim_a[RES_W-1:0] : sh_q[RES_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= '0;
            r_mcnt <= '0;
            r_dact <= 1'b0;
            r_dcnt <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end

            // serial multiply-accumulate, sign bit of multiplier weighs negative
            if (r_mcnt != '0) begin
                if (r_mb[0]) begin
                    r_acc <= (r_mcnt == MCW'(1)) ? r_acc - r_ma : r_acc + r_ma;
                end
                r_ma   <= r_ma << 1;
                r_mb   <= r_mb >> 1;
                r_mcnt <= r_mcnt - MCW'(1);
            end

            // one quotient bit per cycle, then round and saturate
            if (r_dact) begin
                if (r_dcnt != '0) begin
                    r_dr   <= ge ? DW'(r2 - {1'b0, r_dd}) : DW'(r2);
                    r_dn   <= {r_dn[NW-2:0], ge};
                    r_dcnt <= r_dcnt - DCW'(1);
                end else begin
                    r_val  <= r_dneg ? -mag48 : mag48;
                    r_st   <= sat ? ST_SAT : ST_OK;
                    r_dact <= 1'b0;
                end
            end

            case (i_cmd.op)
                OP_START: begin
                    r_q   <= i_query_x;
                    r_s   <= '0;
                    r_acc <= '0;
                end
                OP_LD_FIRST: begin
                    r_xa  <= rd_x;
                    r_ya  <= rd_y;
                    r_idx <= '0;
                end
                OP_LD_LAST: begin
                    r_xl <= rd_x;
                    r_yl <= rd_y;
                    r_t  <= t_new;
                end
                OP_LD_NEXT: begin
                    r_xb <= rd_x;
                    r_yb <= rd_y;
                end
                OP_ADVANCE: begin
                    r_xa  <= r_xb;
                    r_ya  <= r_yb;
                    r_idx <= r_idx + AW'(1);
                end
                OP_MUL_TERM, OP_MUL_YDX, OP_MUL_2YDX, OP_MUL_UDY: begin
                    r_prod <= prod_c;
                end
                OP_S_ADD: begin
                    r_s <= r_s + SW'(r_prod);
                end
                OP_ACC_ADD: begin
                    r_acc <= r_acc + NW'(r_prod);
                end
                OP_SAVE_INNER: begin
                    r_inner <= IW'(r_acc);
                    r_acc   <= '0;
                end
                OP_MAC_S_DX: begin
                    r_ma   <= NW'(r_s);
                    r_mb   <= dx;
                    r_mcnt <= MCW'(MBW);
                end
                OP_MAC_IN_U: begin
                    r_ma   <= NW'(r_inner);
                    r_mb   <= u;
                    r_mcnt <= MCW'(MBW);
                end
                OP_DIV_INT, OP_DIV_SEG: begin
                    r_dn   <= num_mag;
                    r_dr   <= '0;
                    r_dact <= 1'b1;
                    r_dcnt <= DCW'(NW);
                    r_dneg <= num_neg ^ dx[32];
                    if (i_cmd.op == OP_DIV_INT) begin
                        r_dd <= DW'(adx);
                    end else begin
                        r_dd <= DW'(adx) << (FRACTION_BITS + 1);
                    end
                end
                OP_DIV_ALL: begin
                    r_val <= num_neg ? -mag_a : mag_a;
                    r_st  <= sat_a ? ST_SAT : ST_OK;
                end
                OP_RES_SHORT: begin
                    r_val <= '0;
                    r_st  <= ST_SHORT;
                end
                OP_RES_ZW: begin
                    r_val <= '0;
                    r_st  <= ST_ZERO_WIDTH;
                end
                OP_RES_Y0: begin
                    r_val <= RES_W'(r_ya);
                    r_st  <= ST_OK;
                end
                OP_RES_YL: begin
                    r_val <= RES_W'(r_yl);
                    r_st  <= ST_OK;
                end
                OP_PUBLISH: begin
                    r_out_value  <= r_val;
                    r_out_status <= r_st;
                end
                default: begin
                end
            endcase
        end
    end

    // Status back to the controller
    assign o_flags.short_tbl = n_eff < CW'(2);
    assign o_flags.lt_first  = r_q < r_xa;
    assign o_flags.gt_last   = r_q > r_xl;
    assign o_flags.more_idx  = (CW'(r_idx) + CW'(1)) < (n_eff - CW'(1));
    assign o_flags.below_t   = r_xb < r_t;
    assign o_flags.dx_zero   = r_xa == r_xb;
    assign o_flags.mac_busy  = r_mcnt != '0;
    assign o_flags.div_busy  = r_dact;

    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;

endmodule

`default_nettype wire

// ===== rtl/bti_ctrl.sv =====
`default_nettype none

module bti_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_mode,
    input  logic                 i_out_stall,
    input  bti_pkg::t_dp_status  i_flags,
    output bti_pkg::t_cmd        o_cmd,
    output logic                 o_in_stall,
    output logic                 o_out_valid
);
    import bti_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_BEGIN,
        S_FIRST,
        S_LAST,
        S_CLAMP,
        S_NEXT,
        S_EVAL,
        S_TERM,
        S_STEP,
        S_RDN,
        S_SEG,
        S_Y,
        S_U,
        S_U2,
        S_MAC1,
        S_MW1,
        S_MW2,
        S_MW3,
        S_DIV,
        S_PUB
    } t_state;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic   r_out_valid, n_out_valid;
    logic   publish;

    assign publish = (o_cmd.op == OP_PUBLISH);

    // Next state and datapath command
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        o_cmd.op     = OP_NOP;
        o_cmd.rd_sel = RD_NEXT;
        o_cmd.mem_we = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (t_mode'(i_mode) == MODE_LOAD) begin
                        o_cmd.mem_we = 1'b1;
                    end else begin
                        o_cmd.op = OP_START;
                        n_mode   = t_mode'(i_mode);
                        n_state  = S_BEGIN;
                    end
                end
            end
            S_BEGIN: begin
                if (i_flags.short_tbl) begin
                    o_cmd.op = OP_RES_SHORT;
                    n_state  = S_PUB;
                end else begin
                    o_cmd.rd_sel = RD_FIRST;
                    n_state      = S_FIRST;
                end
            end
            S_FIRST: begin
                o_cmd.op     = OP_LD_FIRST;
                o_cmd.rd_sel = RD_LAST;
                n_state      = S_LAST;
            end
            S_LAST: begin
                o_cmd.op = OP_LD_LAST;
                n_state  = S_CLAMP;
            end
            // outside the table an interpolate returns an end ordinate
            S_CLAMP: begin
                if (r_mode == MODE_INTERP && i_flags.lt_first) begin
                    o_cmd.op = OP_RES_Y0;
                    n_state  = S_PUB;
                end else if (r_mode == MODE_INTERP && i_flags.gt_last) begin
                    o_cmd.op = OP_RES_YL;
                    n_state  = S_PUB;
                end else begin
                    n_state = S_NEXT;
                end
            end
            S_NEXT: begin
                o_cmd.op = OP_LD_NEXT;
                n_state  = S_EVAL;
            end
            // walk the table
            S_EVAL: begin
                if (r_mode == MODE_INTEG_ALL) begin
                    o_cmd.op = OP_MUL_TERM;
                    n_state  = S_TERM;
                end else if (i_flags.more_idx && i_flags.below_t) begin
                    if (r_mode == MODE_INTEG_TO) begin
                        o_cmd.op = OP_MUL_TERM;
                        n_state  = S_TERM;
                    end else begin
                        o_cmd.op = OP_ADVANCE;
                        n_state  = S_RDN;
                    end
                end else begin
                    n_state = S_SEG;
                end
            end
            S_TERM: begin
                o_cmd.op = OP_S_ADD;
                n_state  = S_STEP;
            end
            S_STEP: begin
                if (r_mode == MODE_INTEG_ALL && !i_flags.more_idx) begin
                    o_cmd.op = OP_DIV_ALL;
                    n_state  = S_DIV;
                end else begin
                    o_cmd.op = OP_ADVANCE;
                    n_state  = S_RDN;
                end
            end
            S_RDN: begin
                n_state = S_NEXT;
            end
            // segment that holds the target
            S_SEG: begin
                if (i_flags.dx_zero) begin
                    o_cmd.op = OP_RES_ZW;
                    n_state  = S_PUB;
                end else begin
                    o_cmd.op = (r_mode == MODE_INTEG_TO) ? OP_MUL_2YDX : OP_MUL_YDX;
                    n_state  = S_Y;
                end
            end
            S_Y: begin
                o_cmd.op = OP_ACC_ADD;
                n_state  = S_U;
            end
            S_U: begin
                o_cmd.op = OP_MUL_UDY;
                n_state  = S_U2;
            end
            S_U2: begin
                o_cmd.op = OP_ACC_ADD;
                n_state  = (r_mode == MODE_INTEG_TO) ? S_MAC1 : S_MW2;
            end
            S_MAC1: begin
                o_cmd.op = OP_SAVE_INNER;
                n_state  = S_MW1;
            end
            S_MW1: begin
                o_cmd.op = OP_MAC_S_DX;
                n_state  = S_DIV;
                if (!i_flags.mac_busy) begin
                    n_state = S_MW2;
                end
            end
            S_MW2: begin
                if (!i_flags.mac_busy) begin
                    if (r_mode == MODE_INTEG_TO) begin
                        o_cmd.op = OP_MAC_IN_U;
                        n_state  = S_MW3;
                    end else begin
                        o_cmd.op = OP_DIV_INT;
                        n_state  = S_DIV;
                    end
                end
            end
            // second product in, then divide by twice the segment width
            S_MW3: begin
                if (!i_flags.mac_busy) begin
                    o_cmd.op = OP_DIV_SEG;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_flags.div_busy && !i_flags.mac_busy) begin
                    n_state = S_PUB;
                end
            end
            S_PUB: begin
                if (!i_flags.mac_busy && !i_flags.div_busy && (!r_out_valid || !i_out_stall)) begin
                    o_cmd.op = OP_PUBLISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (publish) begin
            n_out_valid = 1'b1;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/breakpoint_table_interpolate_integrate_top.sv =====
// Piecewise-linear breakpoint table. Load items (mode 0) write one (x, y) entry
// and are taken with no result. Queries (interpolate, integrate to query_x,
// integrate whole table) give one result each, rounded to nearest with ties
// away from zero and saturated to signed Q32.16. A short table, and an
// interpolate outside the table, answer without walking the table. Inside the
// table the walk passes one entry at a time; interpolate then divides with the
// restoring divider, integrate-to runs two products through the serial wide
// multiplier before that divider, and integrate-all shifts instead of dividing.
// One item is processed at a time; a finished result waits in the output
// register while the next item is taken, and a query that finishes while that
// result is still stalled waits too.
`default_nettype none

module breakpoint_table_interpolate_integrate_top #(
    parameter int MAX_ENTRIES   = bti_pkg::MAX_ENTRIES_DEF,
    parameter int FRACTION_BITS = bti_pkg::FRACTION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [bti_pkg::CFG_W-1:0]         i_cfg_wr_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_mode,
    input  logic [bti_pkg::IDX_W-1:0]         i_entry_index,
    input  logic signed [bti_pkg::VAL_W-1:0]  i_entry_x,
    input  logic signed [bti_pkg::VAL_W-1:0]  i_entry_y,
    input  logic signed [bti_pkg::VAL_W-1:0]  i_query_x,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [bti_pkg::RES_W-1:0]  o_result_value,
    output logic [1:0]                        o_status
);
    import bti_pkg::*;

    t_cmd       cmd;
    t_dp_status flags;

    bti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .i_out_stall (i_out_stall),
        .i_flags     (flags),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    bti_datapath #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_entry_index  (i_entry_index),
        .i_entry_x      (i_entry_x),
        .i_entry_y      (i_entry_y),
        .i_query_x      (i_query_x),
        .i_cmd          (cmd),
        .o_flags        (flags),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

endmodule

`default_nettype wire

// ===== rtl/bti_checker.sv =====
`default_nettype none

module bti_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic [1:0]                        i_mode,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic signed [bti_pkg::RES_W-1:0]  o_result_value,
    input logic [1:0]                        o_status
);
    import bti_pkg::*;

    // a pending result is not dropped while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // flagged short table or zero-width segment reads as zero
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_SHORT || o_status == ST_ZERO_WIDTH)
        |-> o_result_value == '0)
        else $error("flagged result not zero");

    // saturated result sits on a bound
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_SAT
        |-> (o_result_value == {1'b0, {(RES_W-1){1'b1}}} ||
             o_result_value == {1'b1, {(RES_W-1){1'b0}}}))
        else $error("saturated result not at a bound");

    // a query occupies the block, a load does not
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_mode != MODE_LOAD |=> o_in_stall)
        else $error("query did not occupy the block");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_mode == MODE_LOAD |=> !o_in_stall)
        else $error("load stalled the block");

endmodule

bind breakpoint_table_interpolate_integrate_top bti_checker u_bti_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_mode         (i_mode),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_value (o_result_value),
    .o_status       (o_status)
);

`default_nettype wire
